// ===== hdl/vt4_pkg.sv =====
// vt4_pkg: shared types and constants for the 4x4 vertex transform engine.
// Used by vt4_front, vt4_back and vertex_transform_4x4; depends on nothing.
`timescale 1ns / 1ps

package vt4_pkg;

  // Fixed geometry and default fraction width
  localparam int MATRIX_DIM    = 4;
  localparam int COMP_W        = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item kinds carried in the mode field
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_VECTOR = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Four components, component 0 in the lowest bits
  typedef logic [MATRIX_DIM-1:0][COMP_W-1:0] vec_t;

  // One queued item
  typedef struct packed {
    mode_t      kind;
    logic [1:0] row;
    vec_t       vec;
  } item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

// ===== hdl/vt4_front.sv =====
// vt4_front: accepts input items, drops unused modes and queues the rest.
// Depends on vt4_pkg.
`timescale 1ns / 1ps

module vt4_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  logic [1:0]     s_mode,
  input  logic [1:0]     s_row,
  input  vt4_pkg::vec_t  s_vec,
  input  logic           pop,
  output logic           head_valid,
  output vt4_pkg::item_t head,
  output vt4_pkg::qstat_t stat
);
  import vt4_pkg::*;

  item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              keep;
  logic              push;
  logic              pop_ok;

  // Classify: only loads and transforms go on to the back end
  always_comb begin
    unique case (mode_t'(s_mode)) inside
      MODE_LOAD, MODE_POINT, MODE_VECTOR: keep = 1'b1;
      default:                            keep = 1'b0;
    endcase
  end

  assign s_ready    = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = s_valid && s_ready && keep;
  assign head_valid = (count != '0);
  assign pop_ok     = pop && head_valid;
  assign head       = q[rd_ptr];
  assign count_next = count + QCNT_W'(push) - QCNT_W'(pop_ok);

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: mode_t'(s_mode), row: s_row, vec: s_vec};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  assign stat = '{push: push, pop: pop_ok, count: count};

endmodule

// ===== hdl/vt4_back.sv =====
// vt4_back: matrix registers, row loads and the three-stage transform datapath.
// Depends on vt4_pkg; fed by vt4_front.
`timescale 1ns / 1ps

module vt4_back #(
  parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  vt4_pkg::item_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output vt4_pkg::vec_t  out_vec,
  output logic           out_sat
);
  import vt4_pkg::*;

  localparam int PROD_W = 2 * COMP_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int NENT   = MATRIX_DIM * MATRIX_DIM;
  localparam logic signed [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  MAXV = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0]  MINV = -SUM_W'(64'sd2147483648);

  logic signed [COMP_W-1:0] mat [NENT];
  logic signed [COMP_W-1:0] v   [MATRIX_DIM];
  logic                     en;
  logic                     is_load;

  logic                     s1_valid;
  logic                     s1_point;
  logic signed [PROD_W-1:0] prod [NENT];
  logic                     s2_valid;
  logic                     s2_point;
  logic signed [SUM_W-1:0]  sum [MATRIX_DIM];

  logic signed [SUM_W-1:0]  sh;
  vec_t                     res;
  logic                     sat_any;

  // Whole pipeline moves when the output register is free
  assign en      = !out_valid || out_ready;
  assign pop     = head_valid && en;
  assign is_load = (head.kind == MODE_LOAD);

  // Operand row vector; point mode forces w to one
  always_comb begin
    for (int i = 0; i < MATRIX_DIM; i++) begin
      v[i] = $signed(head.vec[i]);
    end
    if (head.kind == MODE_POINT) begin
      v[MATRIX_DIM-1] = ONE;
    end
  end

  // Matrix: identity at reset, one row written per load item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MATRIX_DIM; r++) begin
        for (int c = 0; c < MATRIX_DIM; c++) begin
          mat[r*MATRIX_DIM+c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (pop && is_load) begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
        mat[{head.row, 2'(j)}] <= $signed(head.vec[j]);
      end
    end
  end

  // Stage 1: sixteen products
  always_ff @(posedge clk) begin
    if (en) begin
      s1_point <= (head.kind == MODE_POINT);
      for (int i = 0; i < MATRIX_DIM; i++) begin
        for (int j = 0; j < MATRIX_DIM; j++) begin
          prod[i*MATRIX_DIM+j] <= PROD_W'(v[i]) * PROD_W'(mat[i*MATRIX_DIM+j]);
        end
      end
    end
  end

  // Stage 2: exact column sums
  always_ff @(posedge clk) begin
    if (en) begin
      s2_point <= s1_point;
      for (int j = 0; j < MATRIX_DIM; j++) begin
        sum[j] <= SUM_W'(prod[j]) + SUM_W'(prod[MATRIX_DIM+j])
                + SUM_W'(prod[2*MATRIX_DIM+j]) + SUM_W'(prod[3*MATRIX_DIM+j]);
      end
    end
  end

  // Scale down (floor) and clip each column
  always_comb begin
    sh      = '0;
    sat_any = 1'b0;
    res     = '0;
    for (int j = 0; j < MATRIX_DIM; j++) begin
      sh = sum[j] >>> FRAC_BITS;
      if (sh > MAXV) begin
        res[j] = COMP_W'(MAXV);
      end else if (sh < MINV) begin
        res[j] = COMP_W'(MINV);
      end else begin
        res[j] = COMP_W'(sh);
      end
      if ((sh > MAXV || sh < MINV) && !(s2_point && j == MATRIX_DIM - 1)) begin
        sat_any = 1'b1;
      end
    end
    if (s2_point) begin
      res[MATRIX_DIM-1] = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= res;
      out_sat <= sat_any;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop && !is_load;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

// ===== hdl/vertex_transform_4x4.sv =====
// vertex_transform_4x4: Q16.16 row-vector times 4x4 matrix transform engine.
// Instantiates vt4_front and vt4_back; depends on vt4_pkg.
//
// Input channel s_axis: tuser carries mode and row index, tdata the four
// components. Mode load writes one matrix row and gives no result; mode
// point transforms (x, y, z, 1) and reports w as zero; mode vector
// transforms all four components; the unused mode is dropped.
// Output channel m_axis: tdata the four result components, tuser the
// saturation flag.
// Throughput: one item per cycle while the receiver does not stall. Accepted
// items other than the unused mode enter a four-entry queue; the back end pops
// one a cycle, unless stalled, into a three-stage pipeline (sixteen parallel
// multipliers, column adders, scale and clip into the output register).
// A row load takes effect for the next item accepted after it.
// Reset: the matrix returns to identity, the queue and pipeline empty.
// When the receiver stalls, the pipeline holds and the queue fills;
// s_axis_tready falls only when the queue is full.
`timescale 1ns / 1ps

module vertex_transform_4x4 #(
  parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // in_x, in_y, in_z, in_w
  input  logic [3:0]   s_axis_tuser,   // mode, row_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic         m_axis_tuser    // saturated
);
  import vt4_pkg::*;

  item_t  head;
  logic   head_valid;
  logic   pop;
  qstat_t q_stat;
  vec_t   out_vec;

  vt4_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_mode     (s_axis_tuser[1:0]),
    .s_row      (s_axis_tuser[3:2]),
    .s_vec      (s_axis_tdata),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .stat       (q_stat)
  );

  vt4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_vec    (out_vec),
    .out_sat    (m_axis_tuser)
  );

  assign m_axis_tdata = out_vec;

  // Unused mode never reaches the queue
  a_drop_unused: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == MODE_NONE) |-> !q_stat.push)
    else $error("unused mode item was queued");

  // Fill count tracks pushes and pops
  a_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (q_stat.count == $past(q_stat.count) + QCNT_W'($past(q_stat.push))
                              - QCNT_W'($past(q_stat.pop))))
    else $error("queue count out of step");

  // Back end pops only a filled queue
  a_pop_filled: assert property (@(posedge clk) disable iff (rst)
    q_stat.pop |-> (q_stat.count != '0))
    else $error("pop from empty queue");

endmodule
